// File: hdl/tbcd_pkg.sv
`default_nettype none

package tbcd_pkg;

	localparam int COUNT_W    = 13;
	localparam int MASK_W     = 12;
	localparam int CHAN_W     = 2;
	localparam int LANE_COUNT = 4;
	localparam int CHAN_COUNT = 4;
	localparam int SLOT_COUNT = CHAN_COUNT * LANE_COUNT;

	localparam logic [COUNT_W-1:0] BASE_MAX        = 13'h1FFF;
	localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 13'd25;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_CAL   = 2'd1,
		FUNC_SENSE = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		logic              fire;
		logic              clear;
		logic              cal_add;
		logic              cal_fail;
		logic              failed;
		logic [CHAN_W-1:0] chan;
	} lane_ctrl_t;

	typedef struct packed {
		logic [MASK_W-1:0] touch_mask;
		logic              frame_done;
		logic              cal_failed;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/tbcd_acq_if.sv
`default_nettype none

interface tbcd_acq_if;
	import tbcd_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [CHAN_W-1:0] channel;
	logic              max_count_error;
	count_t            count_a;
	count_t            count_b;
	count_t            count_c;
	count_t            count_d;

	modport source (
		output valid, func, channel, max_count_error, count_a, count_b, count_c, count_d,
		input  ready
	);
	modport sink (
		input  valid, func, channel, max_count_error, count_a, count_b, count_c, count_d,
		output ready
	);

endinterface

`default_nettype wire

// File: hdl/tbcd_result_if.sv
`default_nettype none

interface tbcd_result_if;
	import tbcd_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] touch_mask;
	logic              frame_done;
	logic              cal_failed;

	modport source (
		output valid, touch_mask, frame_done, cal_failed,
		input  ready
	);
	modport sink (
		input  valid, touch_mask, frame_done, cal_failed,
		output ready
	);

endinterface

`default_nettype wire

// File: hdl/tbcd_cfg_if.sv
`default_nettype none

interface tbcd_cfg_if;
	import tbcd_pkg::*;

	logic   valid;
	logic   ready;
	count_t touch_threshold;

	modport source (
		output valid, touch_threshold,
		input  ready
	);
	modport sink (
		input  valid, touch_threshold,
		output ready
	);

endinterface

`default_nettype wire

// File: hdl/tbcd_lane.sv
`default_nettype none

module tbcd_lane #(
	parameter int CAL_SHIFT    = 3,
	parameter int SENSOR_COUNT = 12,
	parameter int LANE         = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tbcd_pkg::lane_ctrl_t ctrl,
	input  wire tbcd_pkg::count_t     count,
	input  wire tbcd_pkg::count_t     threshold,
	output logic                     hit
);
	import tbcd_pkg::*;

	// One bit wider than a sensor number so a full count of 16 still fits.
	localparam logic [CHAN_W+2:0] SENSOR_LIMIT = (CHAN_W+3)'(SENSOR_COUNT);
	localparam logic [1:0]        LANE_IDX     = 2'(LANE);

	// One baseline per channel for this group position.
	count_t bank_q [CHAN_COUNT];

	count_t            base;
	count_t            drop;
	logic [COUNT_W:0]  sum;
	count_t            sat;
	logic [CHAN_W+1:0] idx;
	logic              in_range;
	logic              below;

	always_comb begin
		base     = bank_q[ctrl.chan];
		drop     = base - count;
		below    = (count < base) && (drop > threshold);
		sum      = {1'b0, base} + {1'b0, count >> CAL_SHIFT};
		sat      = sum[COUNT_W] ? BASE_MAX : sum[COUNT_W-1:0];
		idx      = {ctrl.chan, LANE_IDX};
		in_range = {1'b0, idx} < SENSOR_LIMIT;
		hit      = in_range && (ctrl.failed || below);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHAN_COUNT; c++) bank_q[c] <= '0;
		end else if (ctrl.fire) begin
			if (ctrl.clear) begin
				for (int c = 0; c < CHAN_COUNT; c++) bank_q[c] <= '0;
			end else if (ctrl.cal_fail) begin
				for (int c = 0; c < CHAN_COUNT; c++) bank_q[c] <= BASE_MAX;
			end else if (ctrl.cal_add) begin
				bank_q[ctrl.chan] <= sat;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/tbcd_merge.sv
`default_nettype none

module tbcd_merge #(
	parameter int SENSOR_COUNT = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              fire,
	input  wire logic [1:0]                        func,
	input  wire logic [tbcd_pkg::CHAN_W-1:0]       chan,
	input  wire logic                              err,
	input  wire logic [tbcd_pkg::LANE_COUNT-1:0]   hits,
	output tbcd_pkg::lane_ctrl_t                   ctrl,
	output logic                                   in_ready,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output tbcd_pkg::result_t                      out_data
);
	import tbcd_pkg::*;

	localparam logic [CHAN_W-1:0] LAST_CHANNEL = CHAN_W'((SENSOR_COUNT + 3) / 4 - 1);

	logic                  failed_q;
	logic [SLOT_COUNT-1:0] touch_q;
	logic                  failed_nxt;
	logic [SLOT_COUNT-1:0] touch_nxt;
	logic                  sense;
	logic [3:0]            slot;
	result_t               res;

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	always_comb begin
		ctrl        = '0;
		ctrl.fire   = fire;
		ctrl.chan   = chan;
		ctrl.failed = failed_q;
		sense       = 1'b0;
		failed_nxt  = failed_q;
		case (func_t'(func))
			FUNC_CLEAR: begin
				ctrl.clear = 1'b1;
				failed_nxt = 1'b0;
			end
			FUNC_CAL: begin
				ctrl.cal_add  = !failed_q && !err;
				ctrl.cal_fail = !failed_q && err;
				if (!failed_q && err) failed_nxt = 1'b1;
			end
			FUNC_SENSE: sense = 1'b1;
			default: ;
		endcase

		// Channel 0 opens a new frame: drop the previous mask.
		touch_nxt = (sense && chan == '0) ? '0 : touch_q;
		for (int j = 0; j < SLOT_COUNT; j++) begin
			slot = 4'(j);
			if (sense && !err && slot[3:2] == chan && hits[slot[1:0]]) touch_nxt[j] = 1'b1;
		end

		res.touch_mask = touch_nxt[MASK_W-1:0];
		res.frame_done = sense && chan == LAST_CHANNEL;
		res.cal_failed = failed_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q <= 1'b0;
			touch_q  <= '0;
		end else if (fire) begin
			failed_q <= failed_nxt;
			touch_q  <= touch_nxt;
		end
	end

	// Output register plus one skid entry.
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_ready) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= fire;
				end
			end else if (fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (fire) out_q <= res;
		end else if (fire) begin
			skid_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: hdl/touch_baseline_calibrate_detect_top.sv
`default_nettype none

// Capacitive touch baseline calibration and detection.
// acq carries one acquisition item: a function code (clear, calibrate,
// sense), a channel of four sensors and the four group counts.
// result returns one item per accepted acquisition: the touch mask after
// the update, frame_done on a sense of the last channel, and the
// calibration failure flag.
// cfg writes the touch threshold; it is always ready. Write it only while
// no item is in flight.
// Four lanes, one per group position, each hold the baselines of their
// sensors and do the add/saturate and the threshold compare in parallel;
// the merge stage folds their hits into the mask and registers the result.
// Each result is registered in the merge output register, or in the skid
// entry if the receiver stalls. Throughput: one item per cycle unless the
// skid entry is full, set by the baseline read-modify-write in a lane.
// A full skid entry holds acq.ready low until the held result is taken.
// Reset clears baselines, mask and failure flag and loads threshold 25.
module touch_baseline_calibrate_detect_top #(
	parameter int CAL_SHIFT    = 3,
	parameter int SENSOR_COUNT = 12
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tbcd_acq_if.sink      acq,
	tbcd_result_if.source result,
	tbcd_cfg_if.sink      cfg
);
	import tbcd_pkg::*;

	count_t                threshold_q;
	logic                  fire;
	logic                  in_ready;
	lane_ctrl_t            ctrl;
	count_t                counts [LANE_COUNT];
	logic [LANE_COUNT-1:0] hits;
	result_t               res;
	logic                  res_valid;

	// Threshold register: take every write.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg.valid) begin
			threshold_q <= cfg.touch_threshold;
		end
	end

	assign acq.ready = in_ready;
	assign fire      = acq.valid && in_ready;

	assign counts[0] = acq.count_a;
	assign counts[1] = acq.count_b;
	assign counts[2] = acq.count_c;
	assign counts[3] = acq.count_d;

	// One lane per group position within a channel.
	for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
		tbcd_lane #(
			.CAL_SHIFT    (CAL_SHIFT),
			.SENSOR_COUNT (SENSOR_COUNT),
			.LANE         (g)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.count     (counts[g]),
			.threshold (threshold_q),
			.hit       (hits[g])
		);
	end

	// Decode, fold lane hits into the mask, buffer the result.
	tbcd_merge #(
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.func      (acq.func),
		.chan      (acq.channel),
		.err       (acq.max_count_error),
		.hits      (hits),
		.ctrl      (ctrl),
		.in_ready  (in_ready),
		.out_valid (res_valid),
		.out_ready (result.ready),
		.out_data  (res)
	);

	assign result.valid      = res_valid;
	assign result.touch_mask = res.touch_mask;
	assign result.frame_done = res.frame_done;
	assign result.cal_failed = res.cal_failed;

endmodule

`default_nettype wire

// File: tb/sv/touch_baseline_calibrate_detect_top_test.sv
`default_nettype none

module touch_baseline_calibrate_detect_top_test;
	import tbcd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Match the parameters the block is built with below.
	localparam int CAL_SH      = 3;
	localparam int SENSORS     = 12;
	localparam int LAST_CHAN   = (SENSORS + 3) / 4 - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEG_ITEMS   = 120;

	logic clk = 1'b0;
	logic arst_n;

	tbcd_acq_if    acq_bus ();
	tbcd_result_if res_bus ();
	tbcd_cfg_if    cfg_bus ();

	touch_baseline_calibrate_detect_top #(
		.CAL_SHIFT    (CAL_SH),
		.SENSOR_COUNT (SENSORS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.acq    (acq_bus),
		.result (res_bus),
		.cfg    (cfg_bus)
	);

	// Shadow copy of the block's state, advanced once per accepted item.
	count_t                base_model [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] touch_model;
	logic                  fail_model;
	count_t                thresh_model;

	// Result items owed by the block, oldest first.
	result_t pending_results [$];

	int          items_sent     = 0;
	int          mismatch_count = 0;
	int          src_idle_pct   = 0;
	int          sink_stall_pct = 0;
	int unsigned cycle_count    = 0;

	always #5 clk = ~clk;

	// Advance the shadow state by one acquisition item and return the
	// result item the block must produce for it.
	function automatic result_t apply_acquisition(input func_t f, input logic [1:0] ch,
			input logic err, input count_t a, input count_t b, input count_t c,
			input count_t d);
		count_t           cnt [LANE_COUNT];
		int               idx;
		logic [COUNT_W:0] sum;
		result_t          res;
		cnt[0] = a;
		cnt[1] = b;
		cnt[2] = c;
		cnt[3] = d;
		res.frame_done = 1'b0;
		case (f)
			FUNC_CLEAR: begin
				// The touch mask survives a clear; only baselines and flag drop.
				for (int i = 0; i < SLOT_COUNT; i++)
					base_model[i] = '0;
				fail_model = 1'b0;
			end
			FUNC_CAL: begin
				if (!fail_model) begin
					if (err) begin
						// A failed calibration pins every baseline at the top.
						fail_model = 1'b1;
						for (int i = 0; i < SLOT_COUNT; i++)
							base_model[i] = BASE_MAX;
					end else begin
						for (int i = 0; i < LANE_COUNT; i++) begin
							idx = int'(ch) * LANE_COUNT + i;
							if (idx < SENSORS) begin
								sum = {1'b0, base_model[idx]} + (cnt[i] >> CAL_SH);
								base_model[idx] = (sum > BASE_MAX) ? BASE_MAX
									: sum[COUNT_W-1:0];
							end
						end
					end
				end
			end
			FUNC_SENSE: begin
				// Channel 0 opens a frame: drop the old mask, even on error.
				if (ch == 2'd0)
					touch_model = '0;
				if (!err) begin
					for (int i = 0; i < LANE_COUNT; i++) begin
						idx = int'(ch) * LANE_COUNT + i;
						if (idx < SENSORS && (fail_model || (cnt[i] < base_model[idx]
								&& (base_model[idx] - cnt[i]) > thresh_model)))
							touch_model[idx] = 1'b1;
					end
				end
				res.frame_done = (int'(ch) == LAST_CHAN);
			end
			default: ;
		endcase
		res.touch_mask = touch_model[MASK_W-1:0];
		res.cal_failed = fail_model;
		return res;
	endfunction

	// Pick a count: flat over the range with the extremes weighted up, or
	// biased high so a handful of calibration passes reach saturation.
	function automatic count_t rand_count(input bit high_bias);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return BASE_MAX;
			default: begin
				if (high_bias)
					return count_t'($urandom_range(6000, 8191));
				return count_t'($urandom_range(0, 8191));
			end
		endcase
	endfunction

	// Pick a sense count for sensor idx close to where the compare flips.
	function automatic count_t near_count(input int idx);
		int base_v;
		int drop;
		int v;
		if (idx >= SENSORS)
			return rand_count(1'b0);
		base_v = int'(base_model[idx]);
		case ($urandom_range(0, 3))
			0: drop = int'(thresh_model) + int'($urandom_range(0, 2)) - 1;
			1: drop = int'($urandom_range(0, base_v));
			2: drop = int'($urandom_range(0, 60)) - 30;
			default: return rand_count(1'b0);
		endcase
		v = base_v - drop;
		if (v < 0)
			v = 0;
		if (v > 8191)
			v = 8191;
		return count_t'(v);
	endfunction

	// Send one acquisition item. Enter and leave at a falling edge; valid is
	// left high on return so back-to-back items keep it up without a dip.
	task automatic send_acq(input func_t f, input logic [1:0] ch, input logic err,
			input count_t a, input count_t b, input count_t c, input count_t d);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			acq_bus.valid <= 1'b0;
			@(negedge clk);
		end
		acq_bus.valid           <= 1'b1;
		acq_bus.func            <= f;
		acq_bus.channel         <= ch;
		acq_bus.max_count_error <= err;
		acq_bus.count_a         <= a;
		acq_bus.count_b         <= b;
		acq_bus.count_c         <= c;
		acq_bus.count_d         <= d;
		do
			@(posedge clk);
		while (!acq_bus.ready);
		pending_results.push_back(apply_acquisition(f, ch, err, a, b, c, d));
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed result item has come back, then let
	// the block settle before returning.
	task automatic drain;
		acq_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the threshold register while the block is idle.
	task automatic write_threshold(input count_t value);
		drain();
		cfg_bus.valid           <= 1'b1;
		cfg_bus.touch_threshold <= value;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		thresh_model = value;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Out of reset: zero baselines, so no sense may report touch; frame_done
	// only on the last channel; an unused function code changes nothing.
	task automatic test_reset_state;
		send_acq(FUNC_SENSE, 2'd0, 1'b0, '0, '0, '0, '0);
		send_acq(FUNC_SENSE, 2'd1, 1'b0, '0, '0, '0, '0);
		send_acq(FUNC_SENSE, 2'd2, 1'b0, BASE_MAX, '0, BASE_MAX, '0);
		send_acq(FUNC_NONE, 2'd3, 1'b1, BASE_MAX, BASE_MAX, BASE_MAX, BASE_MAX);
	endtask

	// Build baselines from shifted counts, low bits dropped by the shift;
	// channel 3 has no sensors and must leave everything alone.
	task automatic test_calibration;
		send_acq(FUNC_CLEAR, 2'd0, 1'b0, '0, '0, '0, '0);
		send_acq(FUNC_CAL, 2'd0, 1'b0, BASE_MAX, '0, 13'd7, 13'd4096);
		send_acq(FUNC_CAL, 2'd1, 1'b0, 13'd8, 13'd15, 13'd16, BASE_MAX);
		send_acq(FUNC_CAL, 2'd2, 1'b0, BASE_MAX, BASE_MAX, BASE_MAX, BASE_MAX);
		send_acq(FUNC_CAL, 2'd3, 1'b0, BASE_MAX, BASE_MAX, BASE_MAX, BASE_MAX);
	endtask

	// Sense against those baselines: exactly at and just past the threshold,
	// an erroring channel, and the empty channel 3.
	task automatic test_sense;
		send_acq(FUNC_SENSE, 2'd0, 1'b0, '0, '0, '0, '0);
		send_acq(FUNC_SENSE, 2'd1, 1'b1, '0, '0, '0, '0);
		send_acq(FUNC_SENSE, 2'd2, 1'b0, BASE_MAX, '0, 13'd997, 13'd998);
		send_acq(FUNC_SENSE, 2'd3, 1'b0, '0, '0, '0, '0);
	endtask

	// Threshold at zero reports any drop; at the top it reports nothing.
	task automatic test_threshold_extremes;
		write_threshold('0);
		send_acq(FUNC_SENSE, 2'd0, 1'b0, 13'd1022, '0, '0, 13'd511);
		write_threshold(BASE_MAX);
		send_acq(FUNC_SENSE, 2'd0, 1'b0, '0, '0, '0, '0);
		write_threshold(THRESHOLD_RESET);
	endtask

	// A calibration error latches the flag, later calibration is ignored and
	// every sensor reads touched until a clear; a clear keeps the mask.
	task automatic test_calibration_failure;
		send_acq(FUNC_CLEAR, 2'd1, 1'b1, BASE_MAX, '0, BASE_MAX, '0);
		send_acq(FUNC_CAL, 2'd1, 1'b1, '0, '0, '0, '0);
		send_acq(FUNC_CAL, 2'd0, 1'b0, BASE_MAX, BASE_MAX, BASE_MAX, BASE_MAX);
		send_acq(FUNC_SENSE, 2'd0, 1'b0, BASE_MAX, BASE_MAX, BASE_MAX, BASE_MAX);
		send_acq(FUNC_SENSE, 2'd1, 1'b0, '0, '0, '0, '0);
		send_acq(FUNC_SENSE, 2'd2, 1'b1, '0, '0, '0, '0);
		send_acq(FUNC_SENSE, 2'd0, 1'b1, '0, '0, '0, '0);
		send_acq(FUNC_NONE, 2'd0, 1'b0, '0, '0, '0, '0);
		send_acq(FUNC_CLEAR, 2'd0, 1'b0, '0, '0, '0, '0);
	endtask

	// Mostly whole sessions (clear, calibration passes, sense frames) with
	// random content, plus extra frames on the current baselines and bursts
	// of arbitrary items.
	task automatic test_random_traffic(input int count);
		int         stop_at;
		int         roll;
		int         passes;
		int         frames;
		int         chan_top;
		logic [1:0] ch;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				send_acq(FUNC_CLEAR, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					rand_count(1'b0), rand_count(1'b0), rand_count(1'b0),
					rand_count(1'b0));
				passes = $urandom_range(1, 12);
				for (int p = 0; p < passes; p++) begin
					chan_top = ($urandom_range(0, 9) == 0) ? 3 : LAST_CHAN;
					for (int c = 0; c <= chan_top; c++)
						send_acq(FUNC_CAL, 2'(c), ($urandom_range(0, 99) < 2),
							rand_count(1'b1), rand_count(1'b1), rand_count(1'b1),
							rand_count(1'b1));
				end
			end
			if (roll < 80) begin
				frames = $urandom_range(1, 4);
				for (int f = 0; f < frames; f++) begin
					chan_top = ($urandom_range(0, 9) == 0) ? 3 : LAST_CHAN;
					for (int c = 0; c <= chan_top; c++)
						send_acq(FUNC_SENSE, 2'(c), ($urandom_range(0, 99) < 5),
							near_count(c * 4), near_count(c * 4 + 1),
							near_count(c * 4 + 2), near_count(c * 4 + 3));
				end
			end else begin
				frames = $urandom_range(1, 8);
				for (int n = 0; n < frames; n++) begin
					ch = 2'($urandom_range(0, 3));
					send_acq(func_t'($urandom_range(0, 3)), ch, 1'($urandom_range(0, 1)),
						near_count(ch * 4), rand_count(1'b0), near_count(ch * 4 + 2),
						rand_count(1'b0));
				end
			end
		end
	endtask

	// Stall the result side at the rate of the current phase.
	always @(negedge clk) begin
		res_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Compare each taken result item with the oldest one owed.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result item with none owed: expected nothing, got mask %h done %b fail %b",
					$time, res_bus.touch_mask, res_bus.frame_done, res_bus.cal_failed);
			end else begin
				want = pending_results.pop_front();
				if (res_bus.touch_mask !== want.touch_mask) begin
					mismatch_count++;
					$display("%0t: touch_mask expected %h got %h",
						$time, want.touch_mask, res_bus.touch_mask);
				end
				if (res_bus.frame_done !== want.frame_done) begin
					mismatch_count++;
					$display("%0t: frame_done expected %b got %b",
						$time, want.frame_done, res_bus.frame_done);
				end
				if (res_bus.cal_failed !== want.cal_failed) begin
					mismatch_count++;
					$display("%0t: cal_failed expected %b got %b",
						$time, want.cal_failed, res_bus.cal_failed);
				end
			end
		end
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		count_t thresh_pick [8];
		// Hold every input at a known value through reset.
		arst_n                  = 1'b0;
		acq_bus.valid           = 1'b0;
		acq_bus.func            = FUNC_CLEAR;
		acq_bus.channel         = '0;
		acq_bus.max_count_error = 1'b0;
		acq_bus.count_a         = '0;
		acq_bus.count_b         = '0;
		acq_bus.count_c         = '0;
		acq_bus.count_d         = '0;
		res_bus.ready           = 1'b0;
		cfg_bus.valid           = 1'b0;
		cfg_bus.touch_threshold = '0;
		for (int i = 0; i < SLOT_COUNT; i++)
			base_model[i] = '0;
		touch_model  = '0;
		fail_model   = 1'b0;
		thresh_model = THRESHOLD_RESET;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_reset_state();
		test_calibration();
		test_sense();
		test_threshold_extremes();
		test_calibration_failure();

		// Two threshold settings per idle phase; the extremes come first.
		thresh_pick[0] = '0;
		thresh_pick[1] = BASE_MAX;
		thresh_pick[2] = THRESHOLD_RESET;
		thresh_pick[3] = count_t'($urandom_range(0, 200));
		thresh_pick[4] = 13'd1;
		thresh_pick[5] = count_t'($urandom_range(0, 8191));
		thresh_pick[6] = 13'd8190;
		thresh_pick[7] = count_t'($urandom_range(0, 60));
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 88; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 88; end
				default: begin src_idle_pct = 12; sink_stall_pct = 12; end
			endcase
			for (int k = 0; k < 2; k++) begin
				write_threshold(thresh_pick[phase * 2 + k]);
				test_random_traffic(SEG_ITEMS);
			end
		end

		drain();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
